/* design/gcf_pkg.sv */
// ----------------------------------------------------------------------------
// gcf_pkg
// shared constants, codes and beat types of the gaussian convolution filter
// ----------------------------------------------------------------------------
package gcf_pkg;

   // default geometry
   localparam int RADIUS_DEF     = 2;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int OUT_FIFO_DEPTH = 8;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int COEF_IDX_W = 5;
   localparam int COEF_W     = 16;
   localparam int CHAN_W     = 8;
   localparam int OUT_COL_W  = 10;
   localparam int ROW_W      = 12;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int PROD_W     = COEF_W + CHAN_W;
   localparam int FRAC_W     = 16;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // register reset values
   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [COEF_IDX_W-1:0] coef_index;
      logic [COEF_W-1:0]     coef_value;
      logic [CHAN_W-1:0]     red_in;
      logic [CHAN_W-1:0]     green_in;
      logic [CHAN_W-1:0]     blue_in;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]    red_out;
      logic [CHAN_W-1:0]    green_out;
      logic [CHAN_W-1:0]    blue_out;
      logic [OUT_COL_W-1:0] out_column;
      logic [ROW_W-1:0]     out_row;
      logic                 frame_done;
   } rsp_type;

   // what travels down the pipe next to the sums
   typedef struct packed {
      logic                 border;
      pixel_type            pix;
      logic [OUT_COL_W-1:0] out_column;
      logic [ROW_W-1:0]     out_row;
      logic                 frame_done;
   } emit_info_type;

endpackage

/* design/gcf_line_buf.sv */
// ----------------------------------------------------------------------------
// gcf_line_buf
// line store: one bank per window row, one write and two registered reads
// ----------------------------------------------------------------------------
module gcf_line_buf #(
   parameter int SIDE_N = 5,
   parameter int DEPTH  = 1024,
   parameter int LINE_W = 3,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [LINE_W-1:0]     wr_line,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  gcf_pkg::pixel_type    wr_data,
   input  logic [ADDR_W-1:0]     rd_addr_a,
   input  logic [ADDR_W-1:0]     rd_addr_b,
   output gcf_pkg::pixel_type    rd_data_a [SIDE_N],
   output gcf_pkg::pixel_type    rd_data_b [SIDE_N]
);

   for (genvar b = 0; b < SIDE_N; b++) begin : g_bank
      gcf_pkg::pixel_type mem [DEPTH];

      // one bank: write on its line, both ports read every cycle
      always_ff @(posedge clock) begin
         if (wr_en && (wr_line == LINE_W'(b))) begin
            mem[wr_addr] <= wr_data;
         end
         rd_data_a[b] <= mem[rd_addr_a];
         rd_data_b[b] <= mem[rd_addr_b];
      end
   end

endmodule

/* design/gcf_tap_cell.sv */
// ----------------------------------------------------------------------------
// gcf_tap_cell
// one window column: holds its pixels and kernel column, passes the column on
// to its neighbor and forms the per-channel column sum
// ----------------------------------------------------------------------------
module gcf_tap_cell #(
   parameter int SIDE_N = 5,
   parameter int CSUM_W = gcf_pkg::PROD_W + $clog2(SIDE_N)
) (
   input  logic                                      clock,
   input  logic                                      shift_en,
   input  gcf_pkg::pixel_type [SIDE_N-1:0]           col_in,
   output gcf_pkg::pixel_type [SIDE_N-1:0]           col_out,
   input  logic [SIDE_N-1:0]                         coef_we,
   input  logic [gcf_pkg::COEF_W-1:0]                coef_value,
   output logic [2:0][CSUM_W-1:0]                    col_sum
);

   gcf_pkg::pixel_type [SIDE_N-1:0]                col_ff;
   logic [SIDE_N-1:0][gcf_pkg::COEF_W-1:0]         coef_ff;
   logic [SIDE_N-1:0][2:0][gcf_pkg::PROD_W-1:0]    prod_ff;
   logic [SIDE_N-1:0][2:0][gcf_pkg::PROD_W-1:0]    prod_in;
   logic [2:0][CSUM_W-1:0]                         sum_ff;
   logic [2:0][CSUM_W-1:0]                         sum_in;

   // column shift and kernel load
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
      for (int i = 0; i < SIDE_N; i++) begin
         if (coef_we[i]) begin
            coef_ff[i] <= coef_value;
         end
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   // one product per tap and channel
   always_comb begin
      for (int i = 0; i < SIDE_N; i++) begin
         prod_in[i][0] = gcf_pkg::PROD_W'(coef_ff[i]) * gcf_pkg::PROD_W'(col_ff[i].red);
         prod_in[i][1] = gcf_pkg::PROD_W'(coef_ff[i]) * gcf_pkg::PROD_W'(col_ff[i].green);
         prod_in[i][2] = gcf_pkg::PROD_W'(coef_ff[i]) * gcf_pkg::PROD_W'(col_ff[i].blue);
      end
   end

   // column sum over the registered products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = '0;
         for (int i = 0; i < SIDE_N; i++) begin
            sum_in[c] = sum_in[c] + CSUM_W'(prod_ff[i][c]);
         end
      end
   end

   assign col_out = col_ff;
   assign col_sum = sum_ff;

endmodule

/* design/gcf_out_fifo.sv */
// ----------------------------------------------------------------------------
// gcf_out_fifo
// result queue between the filter pipe and the result channel
// ----------------------------------------------------------------------------
module gcf_out_fifo #(
   parameter int DEPTH = 8,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gcf_pkg::rsp_type    push_data,
   input  logic                pop,
   output gcf_pkg::rsp_type    head,
   output logic [CNT_W-1:0]    count
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   gcf_pkg::rsp_type    mem [DEPTH];
   logic [ADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* design/gaussian_convolution_filter.sv */
// ----------------------------------------------------------------------------
// gaussian_convolution_filter
// streaming (2*RADIUS+1)^2 kernel convolution over raster-order rgb pixels
// ----------------------------------------------------------------------------
// The block takes one beat per clock and keeps that rate: every pixel, coefficient
// or flush beat is accepted in the cycle it is offered as long as the result
// queue has room, and the result that a beat releases travels the pipe stages and
// the result queue. The line store has one bank per window row, each MAX_WIDTH deep
// with one write and two read ports, so a whole window column is fetched in the
// cycle a pixel is written; a row of 2*RADIUS+1 column cells shifts that column
// along, multiplies each tap in parallel and the column sums are added in one
// registered stage. An eight-entry result queue with credit counting lets input
// flow on while a finished result waits on rsp_stall. Results trail the input by
// RADIUS rows plus RADIUS pixels; flush beats drain the tail of a frame. Load all
// kernel coefficients before the first frame. There is no clearing pass after
// reset.
module gaussian_convolution_filter #(
   parameter int RADIUS    = gcf_pkg::RADIUS_DEF,
   parameter int MAX_WIDTH = gcf_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gcf_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gcf_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_we,
   input  logic [gcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SIDE   = 2 * RADIUS + 1;
   localparam int LINE_W = $clog2(SIDE);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = gcf_pkg::ROW_W;
   localparam int H_W    = gcf_pkg::IMG_H_W;
   localparam int RCV_W  = $clog2(MAX_WIDTH * gcf_pkg::MAX_HEIGHT + 2);
   localparam int CSUM_W = gcf_pkg::PROD_W + $clog2(SIDE);
   localparam int TOT_W  = CSUM_W + $clog2(SIDE);
   localparam int FIFO_DEPTH = gcf_pkg::OUT_FIFO_DEPTH;
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   logic [gcf_pkg::IMG_W_W-1:0] img_w_ff;
   logic [gcf_pkg::IMG_H_W-1:0] img_h_ff;

   // input side state
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [LINE_W-1:0] wl_ff, wl_in;
   logic [RCV_W-1:0]  rcv_ff, rcv_in;
   logic [RCV_W-1:0]  backlog_ff, backlog_in;

   // emit side state
   logic [COL_W-1:0]  em_col_ff, em_col_in;
   logic [ROW_W-1:0]  em_row_ff, em_row_in;
   logic [LINE_W-1:0] el_ff, el_in;

   // decode and control
   logic              accept;
   logic              is_pix, is_flush, is_coef;
   logic [WD_W-1:0]   w_c;
   logic [H_W-1:0]    h_c;
   logic [COL_W-1:0]  col_c, ec;
   logic [ROW_W-1:0]  row_c, er;
   logic [RCV_W-1:0]  lag, bl_new;
   logic              emit, border, done, bypass;
   gcf_pkg::pixel_type in_pix;

   // stage 1
   logic                        s1_pix_ff, s1_emit_ff, s1_coef_ff;
   logic [LINE_W-1:0]           s1_wl_ff, s1_el_ff;
   gcf_pkg::pixel_type          s1_pixel_ff;
   logic                        s1_bypass_ff, s1_border_ff, s1_done_ff;
   logic [gcf_pkg::OUT_COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0]            s1_row_ff;
   logic [gcf_pkg::COEF_IDX_W-1:0] s1_cidx_ff;
   logic [gcf_pkg::COEF_W-1:0]  s1_cval_ff;

   // later stages
   logic                        s2_emit_ff, s3_emit_ff, s4_emit_ff, s5_emit_ff;
   gcf_pkg::emit_info_type      s1_info, s2_info_ff, s3_info_ff, s4_info_ff, s5_info_ff;
   logic [2:0][TOT_W-1:0]       total_ff, total_in;

   // line store and cell row
   gcf_pkg::pixel_type              rd_a [SIDE];
   gcf_pkg::pixel_type              rd_b [SIDE];
   gcf_pkg::pixel_type [SIDE-1:0]   new_col;
   gcf_pkg::pixel_type [SIDE-1:0]   cell_col  [SIDE];
   gcf_pkg::pixel_type [SIDE-1:0]   cell_feed [SIDE];
   logic [SIDE-1:0]                 tap_we    [SIDE];
   logic [2:0][CSUM_W-1:0]          cell_sum  [SIDE];

   // result queue
   logic                 fifo_push, fifo_pop;
   gcf_pkg::rsp_type     push_data;
   logic [CNT_W-1:0]     fifo_count;
   logic [2:0]           pending;

   assign accept = req_valid && !req_stall;
   assign in_pix = '{red: req_payload.red_in, green: req_payload.green_in,
                     blue: req_payload.blue_in};

   // action decode
   always_comb begin
      is_pix   = 1'b0;
      is_flush = 1'b0;
      is_coef  = 1'b0;
      unique case (req_payload.action)
         gcf_pkg::ACT_COEF:  is_coef  = accept;
         gcf_pkg::ACT_PIXEL: is_pix   = accept;
         gcf_pkg::ACT_FLUSH: is_flush = accept;
         gcf_pkg::ACT_NOP:   is_coef  = 1'b0;
         default:            is_coef  = 1'b0;
      endcase
   end

   // clamped frame size and window lag
   always_comb begin
      if (img_w_ff == '0) begin
         w_c = WD_W'(1);
      end else if (32'(img_w_ff) > 32'(MAX_WIDTH)) begin
         w_c = WD_W'(MAX_WIDTH);
      end else begin
         w_c = WD_W'(img_w_ff);
      end
      if (img_h_ff == '0) begin
         h_c = H_W'(1);
      end else if (32'(img_h_ff) > 32'(gcf_pkg::MAX_HEIGHT)) begin
         h_c = H_W'(gcf_pkg::MAX_HEIGHT);
      end else begin
         h_c = img_h_ff;
      end
      lag = RCV_W'(RADIUS) * RCV_W'(w_c) + RCV_W'(RADIUS);
   end

   // position counters, backlog and the emit decision
   always_comb begin
      col_c = (32'(in_col_ff) >= 32'(w_c)) ? '0 : in_col_ff;
      row_c = (32'(in_row_ff) >= 32'(h_c)) ? '0 : in_row_ff;
      ec    = (32'(em_col_ff) >= 32'(w_c)) ? '0 : em_col_ff;
      er    = (32'(em_row_ff) >= 32'(h_c)) ? '0 : em_row_ff;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      wl_in      = wl_ff;
      rcv_in     = rcv_ff;
      em_col_in  = em_col_ff;
      em_row_in  = em_row_ff;
      el_in      = el_ff;
      bl_new     = backlog_ff;

      if (is_pix || is_flush) begin
         in_col_in = col_c;
         in_row_in = row_c;
         em_col_in = ec;
         em_row_in = er;
      end

      // pixel write advances the input raster
      if (is_pix) begin
         bl_new = backlog_ff + 1'b1;
         if (32'(col_c) + 1 >= 32'(w_c)) begin
            in_col_in = '0;
            wl_in     = (32'(wl_ff) == SIDE - 1) ? '0 : wl_ff + 1'b1;
            if (32'(row_c) + 1 >= 32'(h_c)) begin
               in_row_in = '0;
               rcv_in    = '0;
            end else begin
               in_row_in = row_c + 1'b1;
               rcv_in    = rcv_ff + 1'b1;
            end
         end else begin
            in_col_in = col_c + 1'b1;
            rcv_in    = rcv_ff + 1'b1;
         end
      end

      emit = (is_pix || is_flush) && (bl_new != '0) &&
             ((bl_new > lag) || (bl_new > rcv_in));

      border = (32'(ec) < RADIUS) || (32'(er) < RADIUS) ||
               (32'(ec) + RADIUS >= 32'(w_c)) || (32'(er) + RADIUS >= 32'(h_c));
      done   = (32'(ec) + 1 == 32'(w_c)) && (32'(er) + 1 == 32'(h_c));
      bypass = is_pix && (el_ff == wl_ff) && (ec == col_c);

      backlog_in = bl_new;
      if (emit) begin
         backlog_in = bl_new - 1'b1;
         if (32'(ec) + 1 >= 32'(w_c)) begin
            em_col_in = '0;
            el_in     = (32'(el_ff) == SIDE - 1) ? '0 : el_ff + 1'b1;
            em_row_in = (32'(er) + 1 >= 32'(h_c)) ? '0 : er + 1'b1;
         end else begin
            em_col_in = ec + 1'b1;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= gcf_pkg::IMAGE_WIDTH_RST;
         img_h_ff <= gcf_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            gcf_pkg::REG_IMAGE_WIDTH:  img_w_ff <= gcf_pkg::IMG_W_W'(csr_wdata);
            gcf_pkg::REG_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            default:                   img_w_ff <= img_w_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         wl_ff      <= '0;
         rcv_ff     <= '0;
         backlog_ff <= '0;
         em_col_ff  <= '0;
         em_row_ff  <= '0;
         el_ff      <= '0;
         s1_pix_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
         s1_coef_ff <= 1'b0;
         s2_emit_ff <= 1'b0;
         s3_emit_ff <= 1'b0;
         s4_emit_ff <= 1'b0;
         s5_emit_ff <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         wl_ff      <= wl_in;
         rcv_ff     <= rcv_in;
         backlog_ff <= backlog_in;
         em_col_ff  <= em_col_in;
         em_row_ff  <= em_row_in;
         el_ff      <= el_in;
         s1_pix_ff  <= is_pix;
         s1_emit_ff <= emit;
         s1_coef_ff <= is_coef;
         s2_emit_ff <= s1_emit_ff;
         s3_emit_ff <= s2_emit_ff;
         s4_emit_ff <= s3_emit_ff;
         s5_emit_ff <= s4_emit_ff;
      end
   end

   // pipe payload
   always_ff @(posedge clock) begin
      s1_wl_ff     <= wl_ff;
      s1_el_ff     <= el_ff;
      s1_pixel_ff  <= in_pix;
      s1_bypass_ff <= bypass;
      s1_border_ff <= border;
      s1_done_ff   <= done;
      s1_col_ff    <= gcf_pkg::OUT_COL_W'(ec);
      s1_row_ff    <= er;
      s1_cidx_ff   <= req_payload.coef_index;
      s1_cval_ff   <= req_payload.coef_value;
      s2_info_ff   <= s1_info;
      s3_info_ff   <= s2_info_ff;
      s4_info_ff   <= s3_info_ff;
      s5_info_ff   <= s4_info_ff;
      total_ff     <= total_in;
   end

   gcf_line_buf #(
      .SIDE_N (SIDE),
      .DEPTH  (MAX_WIDTH),
      .LINE_W (LINE_W),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock     (clock),
      .wr_en     (is_pix),
      .wr_line   (wl_ff),
      .wr_addr   (col_c),
      .wr_data   (in_pix),
      .rd_addr_a (col_c),
      .rd_addr_b (ec),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // new window column: older rows from the store, newest row from the beat
   always_comb begin
      logic [LINE_W:0] ln;
      for (int i = 0; i < SIDE - 1; i++) begin
         ln = (LINE_W + 1)'(s1_wl_ff) + (LINE_W + 1)'(i + 1);
         if (32'(ln) >= SIDE) begin
            ln = ln - (LINE_W + 1)'(SIDE);
         end
         new_col[i] = rd_a[ln[LINE_W-1:0]];
      end
      new_col[SIDE-1] = s1_pixel_ff;
   end

   // pass-through pixel and emit info
   always_comb begin
      s1_info.border     = s1_border_ff;
      s1_info.pix        = s1_bypass_ff ? s1_pixel_ff : rd_b[s1_el_ff];
      s1_info.out_column = s1_col_ff;
      s1_info.out_row    = s1_row_ff;
      s1_info.frame_done = s1_done_ff;
   end

   // kernel load strobes, one per tap
   always_comb begin
      for (int j = 0; j < SIDE; j++) begin
         for (int i = 0; i < SIDE; i++) begin
            tap_we[j][i] = s1_coef_ff && (32'(s1_cidx_ff) == 32'(i * SIDE + j));
         end
      end
   end

   // row of column cells, newest column enters at the right end
   for (genvar j = 0; j < SIDE; j++) begin : g_cell
      if (j == SIDE - 1) begin : g_head
         assign cell_feed[j] = new_col;
      end else begin : g_link
         assign cell_feed[j] = cell_col[j+1];
      end

      gcf_tap_cell #(
         .SIDE_N (SIDE),
         .CSUM_W (CSUM_W)
      ) u_cell (
         .clock      (clock),
         .shift_en   (s1_pix_ff),
         .col_in     (cell_feed[j]),
         .col_out    (cell_col[j]),
         .coef_we    (tap_we[j]),
         .coef_value (s1_cval_ff),
         .col_sum    (cell_sum[j])
      );
   end

   // window total per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         total_in[c] = '0;
         for (int j = 0; j < SIDE; j++) begin
            total_in[c] = total_in[c] + TOT_W'(cell_sum[j][c]);
         end
      end
   end

   // scale, saturate and pick filtered or pass-through
   always_comb begin
      logic [TOT_W-1:0] sc [3];
      logic [gcf_pkg::CHAN_W-1:0] sat [3];
      for (int c = 0; c < 3; c++) begin
         sc[c]  = total_ff[c] >> gcf_pkg::FRAC_W;
         sat[c] = (sc[c] > TOT_W'(8'hFF)) ? 8'hFF : gcf_pkg::CHAN_W'(sc[c]);
      end
      push_data.red_out    = s5_info_ff.border ? s5_info_ff.pix.red   : sat[0];
      push_data.green_out  = s5_info_ff.border ? s5_info_ff.pix.green : sat[1];
      push_data.blue_out   = s5_info_ff.border ? s5_info_ff.pix.blue  : sat[2];
      push_data.out_column = s5_info_ff.out_column;
      push_data.out_row    = s5_info_ff.out_row;
      push_data.frame_done = s5_info_ff.frame_done;
   end

   assign fifo_push = s5_emit_ff;
   assign fifo_pop  = rsp_valid && !rsp_stall;

   gcf_out_fifo #(
      .DEPTH (FIFO_DEPTH),
      .CNT_W (CNT_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .head      (rsp_payload),
      .count     (fifo_count)
   );

   // credits: queued results plus results still in the pipe
   assign pending   = 3'($countones({s1_emit_ff, s2_emit_ff, s3_emit_ff,
                                     s4_emit_ff, s5_emit_ff}));
   assign req_stall = (32'(fifo_count) + 32'(pending)) >= FIFO_DEPTH;
   assign rsp_valid = (fifo_count != '0);

   // queue never takes a beat while full
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      s5_emit_ff |-> (32'(fifo_count) < FIFO_DEPTH))
      else $error("result queue overflow");

   // credit count never exceeds the queue
   a_credit : assert property (@(posedge clock) disable iff (reset)
      (32'(fifo_count) + 32'(pending)) <= FIFO_DEPTH)
      else $error("credit count beyond queue depth");

   // line pointers stay within the banks
   a_line_ptr : assert property (@(posedge clock) disable iff (reset)
      (32'(wl_ff) < SIDE) && (32'(el_ff) < SIDE))
      else $error("line pointer out of range");

   // a result starts only from an accepted pixel or flush beat
   a_emit_src : assert property (@(posedge clock) disable iff (reset)
      s1_emit_ff |-> $past(req_valid && !req_stall &&
                          ((req_payload.action == gcf_pkg::ACT_PIXEL) ||
                           (req_payload.action == gcf_pkg::ACT_FLUSH))))
      else $error("result without pixel or flush beat");

endmodule

/* tb/tb_gaussian_convolution_filter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_convolution_filter
// Streams coefficient, pixel, flush and no-op beats through the filter with
// random gaps on the request side and random stalls on the result side. Each
// accepted beat is fed to a cycle-free software model of the filter, and every
// result beat is checked field by field against the oldest predicted pixel.
// Directed tests cover clamped frame sizes, saturation and an all-zero kernel;
// random frames of small size follow, chained in runs of up to three, each run drained by flush.
// ----------------------------------------------------------------------------
module tb_gaussian_convolution_filter;
   import gcf_pkg::*;

   localparam int RAD        = RADIUS_DEF;
   localparam int SIDE       = 2 * RAD + 1;
   localparam int TAPS       = SIDE * SIDE;
   localparam int MAXW       = MAX_WIDTH_DEF;
   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE     = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model of the filter state
   logic [COEF_W-1:0]   kernel_q [TAPS];
   logic [23:0]         line_mem [SIDE][MAXW];
   int unsigned         width_reg, height_reg;
   int unsigned         in_col, in_row, em_col, em_row, wr_line, em_line;
   int unsigned         backlog_cnt;
   rsp_type             expected_px [$];

   int unsigned         error_count;
   int unsigned         pixels_sent;
   int unsigned         idle_cycles;
   bit                  calm;

   gaussian_convolution_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] sat_chan(longint unsigned s);
      return ((s >> 16) > 255) ? 8'd255 : 8'((s >> 16));
   endfunction

   // advance the model by one accepted beat, queue any pixel it releases
   task automatic filter_predict(req_type b);
      int unsigned     w, h, lag, rcv, ec, er, ln, k;
      longint unsigned sr, sg, sb;
      logic [23:0]     px;
      logic            border;
      rsp_type         r;
      w = clamp_size(width_reg, MAXW);
      h = clamp_size(height_reg, MAX_HEIGHT);
      if (b.action == ACT_COEF) begin
         if (b.coef_index < TAPS) kernel_q[b.coef_index] = b.coef_value;
         return;
      end
      if (b.action == ACT_NOP) return;
      if (in_col >= w) in_col = 0;
      if (in_row >= h) in_row = 0;
      if (em_col >= w) em_col = 0;
      if (em_row >= h) em_row = 0;
      if (b.action == ACT_PIXEL) begin
         line_mem[wr_line][in_col] = {b.red_in, b.green_in, b.blue_in};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            wr_line = (wr_line + 1) % SIDE;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
         backlog_cnt++;
      end
      lag = RAD * w + RAD;
      rcv = in_row * w + in_col;
      if (backlog_cnt == 0 || !(backlog_cnt > lag || backlog_cnt > rcv)) return;
      ec = em_col;
      er = em_row;
      border = ec < RAD || er < RAD || ec + RAD >= w || er + RAD >= h;
      if (border) begin
         px = line_mem[em_line][ec];
         r.red_out   = px[23:16];
         r.green_out = px[15:8];
         r.blue_out  = px[7:0];
      end else begin
         sr = 0; sg = 0; sb = 0;
         for (int i = 0; i < SIDE; i++) begin
            ln = (em_line + SIDE - RAD + i) % SIDE;
            for (int j = 0; j < SIDE; j++) begin
               k  = i * SIDE + j;
               px = line_mem[ln][ec - RAD + j];
               sr += longint'(kernel_q[k]) * px[23:16];
               sg += longint'(kernel_q[k]) * px[15:8];
               sb += longint'(kernel_q[k]) * px[7:0];
            end
         end
         r.red_out   = sat_chan(sr);
         r.green_out = sat_chan(sg);
         r.blue_out  = sat_chan(sb);
      end
      r.out_column = OUT_COL_W'(ec);
      r.out_row    = ROW_W'(er);
      r.frame_done = (ec + 1 == w && er + 1 == h);
      expected_px.push_back(r);
      backlog_cnt--;
      em_col++;
      if (em_col >= w) begin
         em_col = 0;
         em_line = (em_line + 1) % SIDE;
         em_row++;
         if (em_row >= h) em_row = 0;
      end
   endtask

   // offer one beat, hold it until the filter takes it
   task automatic send_beat(req_type b);
      logic st;
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do begin
         @(negedge clock);
         st = req_stall;
         @(posedge clock);
      end while (st);
      filter_predict(b);
   endtask

   function automatic req_type make_beat(logic [ACTION_W-1:0] act);
      req_type b;
      b            = req_type'({$urandom, $urandom});
      b.action     = act;
      return b;
   endfunction

   task automatic send_pixel(logic [23:0] px);
      req_type b;
      b = make_beat(ACT_PIXEL);
      {b.red_in, b.green_in, b.blue_in} = px;
      send_beat(b);
      pixels_sent++;
   endtask

   task automatic send_coef(int unsigned idx, logic [COEF_W-1:0] val);
      req_type b;
      b            = make_beat(ACT_COEF);
      b.coef_index = COEF_IDX_W'(idx);
      b.coef_value = val;
      send_beat(b);
   endtask

   task automatic flush_frame();
      while (backlog_cnt > 0) send_beat(make_beat(ACT_FLUSH));
   endtask

   // wait for the tail to arrive and the pipe to go quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = val & 32'h7ff;
      else height_reg = val & 32'h1fff;
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // one frame of pixels, with some unrelated beats mixed in when noisy
   task automatic stream_frame(int unsigned npix, logic [23:0] fixed_px, bit use_fixed,
                               bit noisy);
      req_type b;
      for (int unsigned n = 0; n < npix; n++) begin
         if (noisy && $urandom_range(99) < 10) begin
            case ($urandom_range(2))
               0: send_beat(make_beat(ACT_NOP));
               1: send_beat(make_beat(ACT_FLUSH));
               default: begin
                  b = make_beat(ACT_COEF);
                  if ($urandom_range(1)) b.coef_index = COEF_IDX_W'($urandom_range(TAPS, 31));
                  send_beat(b);
               end
            endcase
         end
         if (use_fixed) send_pixel(fixed_px);
         else if ($urandom_range(9) == 0) send_pixel($urandom_range(1) ? 24'hffffff : 24'h0);
         else send_pixel(24'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // full kernel load, plus ignored loads and no-op beats
   task automatic test_kernel_load();
      for (int i = 0; i < TAPS; i++) send_coef(i, 16'($urandom_range(0, 5000)));
      send_coef(TAPS, 16'hffff);
      send_coef(31, 16'h0000);
      send_beat(make_beat(ACT_NOP));
      send_beat(make_beat(ACT_FLUSH));
   endtask

   // sizes clamp at 1 and at the maximum, every pixel on the border
   task automatic test_size_extremes();
      set_size(1, 1);
      stream_frame(3, 24'h0, 1'b0, 1'b0);
      set_size(0, 0);
      stream_frame(2, 24'h0, 1'b0, 1'b0);
      flush_frame();
      set_size(2047, 1);
      stream_frame(MAXW, 24'h0, 1'b0, 1'b0);
      flush_frame();
      set_size(1, 8191);
      stream_frame(MAX_HEIGHT, 24'h0, 1'b0, 1'b0);
      flush_frame();
   endtask

   // maximum coefficients on white pixels saturate every channel
   task automatic test_saturation();
      set_size(5, 5);
      for (int i = 0; i < TAPS; i++) send_coef(i, 16'hffff);
      stream_frame(25, 24'hffffff, 1'b1, 1'b0);
      flush_frame();
      stream_frame(25, 24'h0, 1'b0, 1'b0);
      flush_frame();
   endtask

   // zero kernel gives black interior, border passes through
   task automatic test_zero_kernel();
      set_size(7, 6);
      for (int i = 0; i < TAPS; i++) send_coef(i, 16'h0000);
      stream_frame(42, 24'h0, 1'b0, 1'b0);
      flush_frame();
   endtask

   // random small frames, some chained without a flush
   task automatic test_random_frames();
      int unsigned w, h;
      calm = 1'b1;
      while (pixels_sent < 1100 + MAXW + MAX_HEIGHT + 100) begin
         if ($urandom_range(3) == 0) begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 8);
         end else begin
            w = $urandom_range(5, 12);
            h = $urandom_range(5, 10);
         end
         set_size(w, h);
         if ($urandom_range(2) == 0)
            for (int i = 0; i < TAPS; i++) send_coef(i, 16'($urandom_range(0, 8000)));
         for (int f = $urandom_range(1, 3); f > 0; f--)
            stream_frame(w * h, 24'h0, 1'b0, 1'b1);
         flush_frame();
         if (pixels_sent > 1100 + MAXW + MAX_HEIGHT - 600) calm = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------- checking

   always @(negedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_px.size() == 0) begin
            $display("%t: unexpected result beat %p", $realtime, rsp_payload);
            error_count++;
         end else begin
            e = expected_px.pop_front();
            if (rsp_payload.red_out !== e.red_out) begin
               $display("%t: red_out expected %0d actual %0d", $realtime, e.red_out,
                        rsp_payload.red_out);
               error_count++;
            end
            if (rsp_payload.green_out !== e.green_out) begin
               $display("%t: green_out expected %0d actual %0d", $realtime, e.green_out,
                        rsp_payload.green_out);
               error_count++;
            end
            if (rsp_payload.blue_out !== e.blue_out) begin
               $display("%t: blue_out expected %0d actual %0d", $realtime, e.blue_out,
                        rsp_payload.blue_out);
               error_count++;
            end
            if (rsp_payload.out_column !== e.out_column) begin
               $display("%t: out_column expected %0d actual %0d", $realtime, e.out_column,
                        rsp_payload.out_column);
               error_count++;
            end
            if (rsp_payload.out_row !== e.out_row) begin
               $display("%t: out_row expected %0d actual %0d", $realtime, e.out_row,
                        rsp_payload.out_row);
               error_count++;
            end
            if (rsp_payload.frame_done !== e.frame_done) begin
               $display("%t: frame_done expected %0d actual %0d", $realtime, e.frame_done,
                        rsp_payload.frame_done);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_gaussian_convolution_filter failed");
            $finish;
         end
      end
   end

   // result side stalls
   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 8);
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      error_count = 0;
      pixels_sent = 0;
      idle_cycles = 0;
      calm        = 1'b0;
      width_reg   = IMAGE_WIDTH_RST;
      height_reg  = IMAGE_HEIGHT_RST;
      in_col = 0; in_row = 0; em_col = 0; em_row = 0;
      wr_line = 0; em_line = 0; backlog_cnt = 0;
      for (int i = 0; i < TAPS; i++) kernel_q[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_kernel_load();
      test_size_extremes();
      test_saturation();
      test_zero_kernel();
      test_random_frames();
      wait_idle();
      if (error_count == 0) $display("tb_gaussian_convolution_filter passed");
      else $display("tb_gaussian_convolution_filter failed");
      $finish;
   end

endmodule
